[rtl/core/lpbcd_pkg.sv]
// ----------------------------------------------------------------------------
// lpbcd_pkg
// Shared types and constants for the laser point blank and colour delay block.
// ----------------------------------------------------------------------------
package lpbcd_pkg;

    localparam int LEVEL_W   = 16;
    localparam int POS_W     = 16;
    localparam int DELAY_W   = 10;
    localparam int BLANK_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_POINTS  = 2'd0,
        CFG_STARTUP_BLANK = 2'd1,
        CFG_ARMED_ENABLE  = 2'd2
    } t_cfg_idx;

    // Input command codes
    typedef enum logic {
        CMD_POINT   = 1'b0,
        CMD_RESTART = 1'b1
    } t_cmd;

    // One colour sample as held in the history store, red in the low bits
    typedef struct packed {
        logic [LEVEL_W-1:0] intensity;
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } t_colour;

    localparam int COLOUR_W = $bits(t_colour);

    // Colour source selected for the delayed output
    typedef struct packed {
        logic bypass;   // zero delay: use the current colour
        logic black;    // history not yet filled to the delay
    } t_colour_sel;

endpackage

[rtl/core/lpbcd_ram.sv]
// ----------------------------------------------------------------------------
// lpbcd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module lpbcd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/laser_point_blank_and_colour_delay.sv]
// ----------------------------------------------------------------------------
// laser_point_blank_and_colour_delay
// Startup blanking, arming gate and colour-to-position delay for a stream of
// laser scanner points.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  input    | i_in_valid  / o_in_stall     | command, x/y, r/g/b/intensity
//  output   | o_out_valid / i_out_stall    | x/y, delayed r/g/b/intensity
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One point per cycle sustained while the output is not stalled. An accepted
//  point is captured by the history RAM read and the stage register, then by
//  the output register, which offers the result. A restart transaction gives
//  no result. Reset clears control state only; the history RAM is not cleared,
//  since only entries written since restart are read. Under output stall the
//  stage and output register hold, and input stall follows.
//
module laser_point_blank_and_colour_delay
    import lpbcd_pkg::*;
#(
    parameter int MAX_DELAY = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic signed [POS_W-1:0]     i_x_pos,
    input  logic signed [POS_W-1:0]     i_y_pos,
    input  logic        [LEVEL_W-1:0]   i_red_level,
    input  logic        [LEVEL_W-1:0]   i_green_level,
    input  logic        [LEVEL_W-1:0]   i_blue_level,
    input  logic        [LEVEL_W-1:0]   i_intensity_level,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [POS_W-1:0]     o_out_x,
    output logic signed [POS_W-1:0]     o_out_y,
    output logic        [LEVEL_W-1:0]   o_out_red,
    output logic        [LEVEL_W-1:0]   o_out_green,
    output logic        [LEVEL_W-1:0]   o_out_blue,
    output logic        [LEVEL_W-1:0]   o_out_intensity,

    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int DW = $clog2(MAX_DELAY + 1);
    localparam int CW = (DW > DELAY_W) ? DW : DELAY_W;

    // Configuration
    logic [DELAY_W-1:0] r_delay;
    logic [BLANK_W-1:0] r_startup;
    logic               r_armed;

    // Control state
    logic [BLANK_W-1:0] r_blank, n_blank;
    logic [AW-1:0]      r_wr_idx, n_wr_idx;
    logic [DW-1:0]      r_fill, n_fill;

    // Stage 1 (history read in flight)
    logic                      r_s1_valid, n_s1_valid;
    logic signed [POS_W-1:0]   r_s1_x, r_s1_y;
    t_colour                   r_s1_colour;
    t_colour_sel               r_s1_sel;

    // Output register
    logic                      r_out_valid, n_out_valid;
    logic signed [POS_W-1:0]   r_out_x, r_out_y;
    t_colour                   r_out_colour;

    logic                      s1_adv;
    logic                      in_acc;
    logic                      point_acc;
    logic                      restart_acc;
    logic [CW-1:0]             delay_ext;
    logic [DW-1:0]             delay_sat;
    logic [DW-1:0]             wr_ext;
    logic [DW-1:0]             rd_ext;
    logic [AW-1:0]             rd_idx;
    t_colour                   in_colour;
    t_colour                   gated_colour;
    logic signed [POS_W-1:0]   gated_x, gated_y;
    t_colour_sel               sel;
    t_colour                   hist_colour;
    t_colour                   shown_colour;
    logic [COLOUR_W-1:0]       ram_rd_data;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign point_acc   = in_acc && (i_command == CMD_POINT);
    assign restart_acc = in_acc && (i_command == CMD_RESTART);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Blanking, arming gate and history addressing
    // ------------------------------------------------------------------
    assign in_colour = '{intensity: i_intensity_level, blue: i_blue_level,
                         green: i_green_level, red: i_red_level};

    always_comb begin
        gated_colour = in_colour;
        gated_x      = i_x_pos;
        gated_y      = i_y_pos;
        if (r_blank != '0) begin
            gated_colour = '0;
        end
        if (!r_armed) begin
            gated_colour = '0;
            gated_x      = '0;
            gated_y      = '0;
        end
    end

    // Saturate the delay at the store depth
    assign delay_ext = CW'(r_delay);
    assign delay_sat = (delay_ext > CW'(MAX_DELAY)) ? DW'(MAX_DELAY) : DW'(delay_ext);
    assign wr_ext    = DW'(r_wr_idx);

    // Entry written delay_sat points ago, wrapped around the store
    always_comb begin
        if (wr_ext >= delay_sat) begin
            rd_ext = wr_ext - delay_sat;
        end else begin
            rd_ext = wr_ext + DW'(MAX_DELAY) - delay_sat;
        end
    end
    assign rd_idx = rd_ext[AW-1:0];

    assign sel.bypass = (delay_sat == '0);
    assign sel.black  = (r_fill < delay_sat);

    always_comb begin
        n_blank  = r_blank;
        n_wr_idx = r_wr_idx;
        n_fill   = r_fill;
        if (restart_acc) begin
            n_blank  = r_startup;
            n_wr_idx = '0;
            n_fill   = '0;
        end else if (point_acc) begin
            if (r_blank != '0) begin
                n_blank = r_blank - 1'b1;
            end
            if (wr_ext == DW'(MAX_DELAY - 1)) begin
                n_wr_idx = '0;
            end else begin
                n_wr_idx = r_wr_idx + 1'b1;
            end
            if (r_fill != DW'(MAX_DELAY)) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    lpbcd_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (MAX_DELAY)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (point_acc),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (gated_colour),
        .i_rd_en   (point_acc),
        .i_rd_addr (rd_idx),
        .o_rd_data (ram_rd_data)
    );

    assign hist_colour = t_colour'(ram_rd_data);

    always_comb begin
        if (r_s1_sel.bypass) begin
            shown_colour = r_s1_colour;
        end else if (r_s1_sel.black) begin
            shown_colour = '0;
        end else begin
            shown_colour = hist_colour;
        end
    end

    // ------------------------------------------------------------------
    // Valid flags
    // ------------------------------------------------------------------
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (point_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay   <= '0;
            r_startup <= BLANK_W'(30);
            r_armed   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DELAY_POINTS:  r_delay   <= i_cfg_data[DELAY_W-1:0];
                CFG_STARTUP_BLANK: r_startup <= i_cfg_data[BLANK_W-1:0];
                CFG_ARMED_ENABLE:  r_armed   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank     <= '0;
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_blank     <= n_blank;
            r_wr_idx    <= n_wr_idx;
            r_fill      <= n_fill;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (point_acc) begin
            r_s1_x      <= gated_x;
            r_s1_y      <= gated_y;
            r_s1_colour <= gated_colour;
            r_s1_sel    <= sel;
        end
        if (s1_adv) begin
            r_out_x      <= r_s1_x;
            r_out_y      <= r_s1_y;
            r_out_colour <= shown_colour;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_out_red       = r_out_colour.red;
    assign o_out_green     = r_out_colour.green;
    assign o_out_blue      = r_out_colour.blue;
    assign o_out_intensity = r_out_colour.intensity;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DW'(MAX_DELAY))
        else $error("history fill count beyond store depth");

    a_wr_idx_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DW'(r_wr_idx) < DW'(MAX_DELAY))
        else $error("history write index beyond store depth");

    a_restart_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart_acc |=> (r_fill == '0) && (r_wr_idx == '0))
        else $error("restart did not empty the history");

    a_restart_no_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (restart_acc && !r_s1_valid) |=> !r_s1_valid)
        else $error("restart transaction produced a result");

endmodule
